// ===== src/fds_pkg.sv =====
`default_nettype none

package fds_pkg;

  // Stack geometry
  localparam int DEPTH       = 64;
  localparam int HANDLE_BITS = 32;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int OFF_W       = 6;
  localparam int CMP_W       = (CNT_W > OFF_W) ? CNT_W : OFF_W;

  // Command codes; code 7 is unused and does nothing
  typedef enum logic [2:0] {
    CMD_PUSH = 3'd0,
    CMD_POP  = 3'd1,
    CMD_PEEK = 3'd2,
    CMD_DUP  = 3'd3,
    CMD_SWAP = 3'd4,
    CMD_OVER = 3'd5,
    CMD_DROP = 3'd6
  } cmd_e;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;

  typedef struct packed {
    logic [2:0]  cmd;
    logic        push_kind;
    logic [31:0] push_handle;
    logic [5:0]  peek_offset;
  } in_item_t;

  typedef struct packed {
    logic        out_kind;
    logic [31:0] out_handle;
    logic [1:0]  status;
    logic        retain;
    logic        release_res;
    logic [6:0]  depth_now;
  } out_item_t;

  // One stored stack entry
  typedef struct packed {
    logic                   kind;
    logic [HANDLE_BITS-1:0] handle;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic check;
    logic step_a;
    logic step_b;
    logic step_c;
    logic emit;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic early;
    logic is_swap;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== src/fds_ram.sv =====
`default_nettype none

module fds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/fds_ctrl.sv =====
`default_nettype none

module fds_ctrl
  import fds_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire dp_stat_t  stat,
  output ctrl_cmd_t      cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CHECK  = 6'b000010,
    S_RDA    = 6'b000100,
    S_RDB    = 6'b001000,
    S_WR2    = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state, state_next;

  // Sequence one command through check, reads, writes and hand-off
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = stat.early ? S_FINISH : S_RDA;
      end
      S_RDA: begin
        cmd.step_a = 1'b1;
        state_next = stat.is_swap ? S_RDB : S_FINISH;
      end
      S_RDB: begin
        cmd.step_b = 1'b1;
        state_next = S_WR2;
      end
      S_WR2: begin
        cmd.step_c = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

endmodule

`default_nettype wire

// ===== src/fds_dp.sv =====
`default_nettype none

module fds_dp
  import fds_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire in_item_t  in_data,
  input  wire ctrl_cmd_t cmd,
  output dp_stat_t       stat,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  logic [2:0]             op;
  logic                   p_kind;
  logic [HANDLE_BITS-1:0] p_handle;
  logic [OFF_W-1:0]       p_off;
  logic [CNT_W-1:0]       count;
  entry_t                 ea;
  out_item_t              res;
  out_item_t              res_out;

  logic [CNT_W-1:0]  cnt_m1, cnt_m2;
  logic [CMP_W-1:0]  peek_idx;
  logic [1:0]        st;
  logic              nop;
  logic              full;
  logic [ADDR_W-1:0] addr_a;
  entry_t            push_e;

  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  entry_t            wdata, rdata;

  function automatic out_item_t mk_res(entry_t e, logic [1:0] s, logic ret, logic rel);
    out_item_t r;
    r.out_kind    = e.kind;
    r.out_handle  = 32'(e.handle);
    r.status      = s;
    r.retain      = ret;
    r.release_res = rel;
    r.depth_now   = '0;
    return r;
  endfunction

  assign cnt_m1   = count - CNT_W'(1);
  assign cnt_m2   = count - CNT_W'(2);
  assign peek_idx = CMP_W'(count) - CMP_W'(1) - CMP_W'(p_off);
  assign full     = (count == CNT_W'(DEPTH));
  assign push_e   = '{kind: p_kind, handle: p_handle};

  // Classify the held command against the current depth
  always_comb begin
    st  = ST_OK;
    nop = 1'b0;
    case (op)
      CMD_PUSH: if (full) st = ST_OVER;
      CMD_POP,
      CMD_DROP: if (count == '0) st = ST_UNDER;
      CMD_PEEK: if (CMP_W'(p_off) >= CMP_W'(count)) st = ST_UNDER;
      CMD_DUP: begin
        if (count == '0) st = ST_UNDER;
        else if (full)   st = ST_OVER;
      end
      CMD_OVER: begin
        if (count < CNT_W'(2)) st = ST_UNDER;
        else if (full)         st = ST_OVER;
      end
      CMD_SWAP: if (count < CNT_W'(2)) st = ST_UNDER;
      default:  nop = 1'b1;
    endcase
  end

  // Pick the first entry to read
  always_comb begin
    case (op)
      CMD_PEEK: addr_a = ADDR_W'(peek_idx);
      CMD_OVER: addr_a = ADDR_W'(cnt_m2);
      default:  addr_a = ADDR_W'(cnt_m1);
    endcase
  end

  assign stat.early    = (st != ST_OK) || nop || (op == CMD_PUSH);
  assign stat.is_swap  = (op == CMD_SWAP);
  assign stat.out_free = !out_valid || !out_stall;

  // Drive the stack memory ports
  always_comb begin
    we    = 1'b0;
    waddr = ADDR_W'(count);
    wdata = push_e;
    re    = 1'b0;
    raddr = addr_a;
    if (cmd.check) begin
      if (st == ST_OK && op == CMD_PUSH) begin
        we = 1'b1;
      end else if (!stat.early) begin
        re = 1'b1;
      end
    end
    if (cmd.step_a) begin
      if (op == CMD_DUP || op == CMD_OVER) begin
        we    = 1'b1;
        wdata = rdata;
      end
      if (op == CMD_SWAP) begin
        re    = 1'b1;
        raddr = ADDR_W'(cnt_m2);
      end
    end
    if (cmd.step_b) begin
      we    = 1'b1;
      waddr = ADDR_W'(cnt_m1);
      wdata = rdata;
    end
    if (cmd.step_c) begin
      we    = 1'b1;
      waddr = ADDR_W'(cnt_m2);
      wdata = ea;
    end
  end

  fds_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Track depth and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.check && st == ST_OK && op == CMD_PUSH) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.step_a) begin
        if (op == CMD_POP || op == CMD_DROP) begin
          count <= cnt_m1;
        end else if (op == CMD_DUP || op == CMD_OVER) begin
          count <= count + CNT_W'(1);
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Stamp the current depth onto the held result
  always_comb begin
    res_out           = res;
    res_out.depth_now = 7'(count);
  end

  // Hold the command, build the result and load the output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op       <= in_data.cmd;
      p_kind   <= in_data.push_kind;
      p_handle <= in_data.push_handle[HANDLE_BITS-1:0];
      p_off    <= in_data.peek_offset;
    end
    if (cmd.check) begin
      if (st == ST_OK && op == CMD_PUSH) begin
        res <= mk_res(push_e, ST_OK, 1'b1, 1'b0);
      end else begin
        res <= mk_res('0, st, 1'b0, 1'b0);
      end
    end
    if (cmd.step_a) begin
      if (op == CMD_SWAP) begin
        ea <= rdata;
      end else begin
        res <= mk_res(rdata, ST_OK, (op == CMD_DUP) || (op == CMD_OVER),
                      (op == CMD_DROP));
      end
    end
    if (cmd.step_b) begin
      res <= mk_res(rdata, ST_OK, 1'b0, 1'b0);
    end
    if (cmd.emit) begin
      out_data <= res_out;
    end
  end

endmodule

`default_nettype wire

// ===== src/forth_data_stack_unit.sv =====
// Sequencing: push, error and unused commands go from the check state to finish;
//   pop, peek, drop, dup and over pass through S_RDA; swap through S_RDA, S_RDB, S_WR2.
// The entry memory has a single read and a single write port; the result register lets
//   the next command be taken while a result waits.
// Reset: synchronous, clears the depth and the output valid; stack memory is not cleared.
`default_nettype none

module forth_data_stack_unit
  import fds_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  fds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  fds_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== dv/stack_checker.sv =====
module stack_checker
  import fds_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire logic      in_stall,
  input  wire in_item_t  in_data,
  input  wire logic      out_valid,
  input  wire logic      out_stall,
  input  wire out_item_t out_data,
  output int             pending,
  output int             fail_count,
  output int             n_results,
  output int             n_underflow,
  output int             n_overflow,
  output int             peak_depth
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the stack and the results still owed by the block
  entry_t    shadow_entries [DEPTH];
  int        shadow_depth = 0;
  out_item_t owed_results [$];
  int        mismatches = 0;
  int        results_seen = 0;
  int        underflows = 0;
  int        overflows = 0;
  int        deepest = 0;

  // Print one line per mismatch and count it
  task automatic report_mismatch(string msg);
    mismatches++;
    $display("[%0t] result %0d: %s", $time, results_seen, msg);
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
  endtask

  // Apply one command to the shadow stack and return the result it must give
  function automatic out_item_t apply_stack_cmd(in_item_t item);
    out_item_t res;
    entry_t    elem;
    int        need;
    logic      has_elem;
    res      = '0;
    elem     = '0;
    has_elem = 1'b0;
    case (item.cmd)
      CMD_PUSH: begin
        if (shadow_depth >= DEPTH) begin
          res.status = ST_OVER;
        end else begin
          elem.kind   = item.push_kind;
          elem.handle = item.push_handle[HANDLE_BITS-1:0];
          shadow_entries[shadow_depth] = elem;
          shadow_depth++;
          has_elem   = 1'b1;
          res.retain = 1'b1;
        end
      end
      CMD_POP, CMD_DROP: begin
        if (shadow_depth == 0) begin
          res.status = ST_UNDER;
        end else begin
          shadow_depth--;
          elem            = shadow_entries[shadow_depth];
          has_elem        = 1'b1;
          res.release_res = (item.cmd == CMD_DROP);
        end
      end
      CMD_PEEK: begin
        if (int'(item.peek_offset) >= shadow_depth) begin
          res.status = ST_UNDER;
        end else begin
          elem     = shadow_entries[shadow_depth - 1 - int'(item.peek_offset)];
          has_elem = 1'b1;
        end
      end
      CMD_DUP, CMD_OVER: begin
        need = (item.cmd == CMD_DUP) ? 1 : 2;
        // underflow takes priority over overflow
        if (shadow_depth < need) begin
          res.status = ST_UNDER;
        end else if (shadow_depth >= DEPTH) begin
          res.status = ST_OVER;
        end else begin
          elem = shadow_entries[shadow_depth - need];
          shadow_entries[shadow_depth] = elem;
          shadow_depth++;
          has_elem   = 1'b1;
          res.retain = 1'b1;
        end
      end
      CMD_SWAP: begin
        if (shadow_depth < 2) begin
          res.status = ST_UNDER;
        end else begin
          elem = shadow_entries[shadow_depth - 1];
          shadow_entries[shadow_depth - 1] = shadow_entries[shadow_depth - 2];
          shadow_entries[shadow_depth - 2] = elem;
          elem     = shadow_entries[shadow_depth - 1];
          has_elem = 1'b1;
        end
      end
      default: begin
        // unused code: no effect on the stack, zero result apart from depth_now
      end
    endcase
    if (has_elem) begin
      res.out_kind   = elem.kind;
      res.out_handle = 32'(elem.handle);
    end
    res.depth_now = 7'(shadow_depth);
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      shadow_depth = 0;
      owed_results.delete();
    end else begin
      // Check a result transfer against the oldest owed result
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        results_seen++;
        if (owed_results.size() == 0) begin
          report_mismatch("result transfer with nothing owed");
        end else begin
          want = owed_results.pop_front();
          compare_field("out_kind", 32'(out_data.out_kind), 32'(want.out_kind));
          compare_field("out_handle", out_data.out_handle, want.out_handle);
          compare_field("status", 32'(out_data.status), 32'(want.status));
          compare_field("retain", 32'(out_data.retain), 32'(want.retain));
          compare_field("release_res", 32'(out_data.release_res), 32'(want.release_res));
          compare_field("depth_now", 32'(out_data.depth_now), 32'(want.depth_now));
        end
      end
      // Predict the result of a command transfer
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        want = apply_stack_cmd(in_data);
        owed_results.push_back(want);
        if (want.status == ST_UNDER) underflows++;
        if (want.status == ST_OVER) overflows++;
        if (shadow_depth > deepest) deepest = shadow_depth;
      end
    end
    pending     <= owed_results.size();
    fail_count  <= mismatches;
    n_results   <= results_seen;
    n_underflow <= underflows;
    n_overflow  <= overflows;
    peak_depth  <= deepest;
  end

endmodule

// ===== dv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fds_pkg::*;

  localparam logic [2:0] CMD_UNUSED  = 3'd7;
  localparam int         QUIET_LIMIT = 2000;
  localparam int         BURST_LEN   = 80;

  typedef enum int {MIX_GROW, MIX_BALANCED, MIX_SHRINK} mix_e;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int pending;
  int fail_count;
  int n_results;
  int n_underflow;
  int n_overflow;
  int peak_depth;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  int n_sent = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  forth_data_stack_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  stack_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .pending     (pending),
    .fail_count  (fail_count),
    .n_results   (n_results),
    .n_underflow (n_underflow),
    .n_overflow  (n_overflow),
    .peak_depth  (peak_depth)
  );

  // Stall the result side at random
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Abort when no transfer happens for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("no transfer for %0d cycles, %0d results still owed", QUIET_LIMIT, pending);
        $display("[forth_data_stack_unit] ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic in_item_t make_cmd(logic [2:0] code, logic kind, logic [31:0] handle,
                                        logic [5:0] offset);
    in_item_t item;
    item.cmd         = code;
    item.push_kind   = kind;
    item.push_handle = handle;
    item.peek_offset = offset;
    return item;
  endfunction

  // Choose a command, weighted to grow, shrink or churn the stack
  function automatic logic [2:0] pick_cmd(mix_e mix);
    int         cut [7];
    logic [2:0] order [7];
    int         roll;
    order = '{CMD_PUSH, CMD_DUP, CMD_OVER, CMD_SWAP, CMD_PEEK, CMD_POP, CMD_DROP};
    case (mix)
      MIX_GROW:   cut = '{45, 60, 75, 82, 90, 94, 97};
      MIX_SHRINK: cut = '{12, 16, 20, 30, 40, 70, 97};
      default:    cut = '{30, 40, 50, 60, 72, 84, 96};
    endcase
    roll = $urandom_range(99);
    for (int i = 0; i < 7; i++)
      if (roll < cut[i]) return order[i];
    return CMD_UNUSED;
  endfunction

  function automatic in_item_t random_cmd(mix_e mix);
    logic [5:0] offset;
    // keep most peeks near the top so that many of them hit
    offset = $urandom_range(1) ? 6'($urandom_range(63)) : 6'($urandom_range(7));
    return make_cmd(pick_cmd(mix), 1'($urandom_range(1)), $urandom, offset);
  endfunction

  // Present one command and hold it until the transfer
  task automatic send_cmd(in_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    n_sent++;
  endtask

  // Hold off new commands until every owed result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_phase(int idle_pct, int stall_rate);
    send_idle_pct = idle_pct;
    stall_pct    <= stall_rate;
  endtask

  initial begin
    mix_e burst_mix [8];
    burst_mix = '{MIX_GROW, MIX_BALANCED, MIX_SHRINK, MIX_GROW,
                  MIX_GROW, MIX_SHRINK, MIX_BALANCED, MIX_SHRINK};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Underflow on every command but push against an empty stack, then the unused code
    send_cmd(make_cmd(CMD_POP, 1'b0, 32'h0, 6'd0));
    send_cmd(make_cmd(CMD_DROP, 1'b0, 32'h0, 6'd0));
    send_cmd(make_cmd(CMD_PEEK, 1'b0, 32'h0, 6'd0));
    send_cmd(make_cmd(CMD_DUP, 1'b0, 32'h0, 6'd0));
    send_cmd(make_cmd(CMD_SWAP, 1'b0, 32'h0, 6'd0));
    send_cmd(make_cmd(CMD_OVER, 1'b0, 32'h0, 6'd0));
    send_cmd(make_cmd(CMD_UNUSED, 1'b1, 32'hFFFF_FFFF, 6'h3F));
    // Single entry: swap, over and deep peek still underflow
    send_cmd(make_cmd(CMD_PUSH, 1'b0, 32'h0, 6'h3F));
    send_cmd(make_cmd(CMD_SWAP, 1'b1, 32'hFFFF_FFFF, 6'd0));
    send_cmd(make_cmd(CMD_OVER, 1'b0, 32'h0, 6'd0));
    send_cmd(make_cmd(CMD_PEEK, 1'b0, 32'h0, 6'd1));
    // Extremes of kind and handle, then every stack shuffle
    send_cmd(make_cmd(CMD_PUSH, 1'b1, 32'hFFFF_FFFF, 6'd0));
    send_cmd(make_cmd(CMD_SWAP, 1'b0, 32'h0, 6'd0));
    send_cmd(make_cmd(CMD_OVER, 1'b0, 32'h0, 6'd0));
    send_cmd(make_cmd(CMD_DUP, 1'b0, 32'h0, 6'd0));
    send_cmd(make_cmd(CMD_PEEK, 1'b0, 32'h0, 6'd3));
    send_cmd(make_cmd(CMD_PEEK, 1'b0, 32'h0, 6'd4));
    send_cmd(make_cmd(CMD_PEEK, 1'b0, 32'h0, 6'h3F));
    send_cmd(make_cmd(CMD_POP, 1'b1, 32'hA5A5_5A5A, 6'd0));
    send_cmd(make_cmd(CMD_DROP, 1'b0, 32'h0, 6'd0));
    send_cmd(make_cmd(CMD_UNUSED, 1'b0, 32'h0, 6'd0));
    // Empty the stack and underflow once more
    send_cmd(make_cmd(CMD_DROP, 1'b0, 32'h0, 6'd0));
    send_cmd(make_cmd(CMD_DROP, 1'b0, 32'h0, 6'd0));
    send_cmd(make_cmd(CMD_POP, 1'b0, 32'h0, 6'd0));
    drain_results();

    // Random bursts; growth bursts run the stack into overflow
    for (int b = 0; b < 8; b++) begin
      case (b % 4)
        0:       set_phase(0, 0);
        1:       set_phase(51, 0);
        2:       set_phase(0, 51);
        default: set_phase(8, 8);
      endcase
      repeat (BURST_LEN) send_cmd(random_cmd(burst_mix[b]));
      drain_results();
    end

    set_phase(0, 0);
    repeat (8) @(posedge clk);
    $display("Sent %0d stack commands, checked %0d results, over four idle and stall mixes.",
             n_sent, n_results);
    $display("Saw %0d underflows and %0d overflows; the stack reached %0d of %0d entries.",
             n_underflow, n_overflow, peak_depth, DEPTH);
    if (fail_count == 0) begin
      $display("[forth_data_stack_unit] OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("[forth_data_stack_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/fds_pkg.sv
src/fds_ram.sv
src/fds_ctrl.sv
src/fds_dp.sv
src/forth_data_stack_unit.sv
dv/stack_checker.sv
dv/tb.sv
